// File: rtl/crcc_pkg.sv
// Package for the CRC codeword checker: item types, the per-item step bundle,
// configuration register indexes and reset values. No dependencies.
package crcc_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_header;
  } crcc_in_t;

  typedef struct packed {
    logic [7:0]  dataword;
    logic        crc_error;
    logic        byte_ready;
    logic [7:0]  data_byte;
    logic [31:0] codeword_total;
    logic [31:0] error_total;
    logic        last_of_run;
  } crcc_out_t;

  typedef struct packed {
    logic [1:0] num;
    crcc_out_t  first;
    crcc_out_t  second;
  } crcc_step_t;

  localparam logic [1:0] CFG_GEN_POLY   = 2'd0;
  localparam logic [1:0] CFG_GEN_LEN    = 2'd1;
  localparam logic [1:0] CFG_DW_EIGHT   = 2'd2;

  localparam logic [31:0] GEN_POLY_RST  = 32'd11;
  localparam logic [5:0]  GEN_LEN_RST   = 6'd4;

  localparam logic [3:0]  DW_NARROW     = 4'd4;
  localparam logic [3:0]  DW_WIDE       = 4'd8;
  localparam logic [3:0]  PACK_FULL     = 4'd8;

endpackage

// File: rtl/crcc_core.sv
// Stream state and the eight unrolled GF(2) division steps for one byte.
// Depends on crcc_pkg.
module crcc_core #(
  parameter int MAX_GEN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  crcc_pkg::crcc_in_t  item,
  input  logic [31:0]         gen_poly,
  input  logic [5:0]          gen_len,
  input  logic                dw_eight,
  output crcc_pkg::crcc_step_t step
);
  import crcc_pkg::*;

  localparam int REM_W = (MAX_GEN_BITS > 1) ? MAX_GEN_BITS - 1 : 1;
  localparam int CBW   = $clog2(MAX_GEN_BITS + 8);

  logic [7:0]       pad_r,  pad_nxt;
  logic [REM_W-1:0] rem_r,  rem_nxt;
  logic [7:0]       ds_r,   ds_nxt;
  logic [CBW-1:0]   cbc_r,  cbc_nxt;
  logic [7:0]       pb_r,   pb_nxt;
  logic [3:0]       pbc_r,  pbc_nxt;
  logic [31:0]      cw_r,   cw_nxt;
  logic [31:0]      err_r,  err_nxt;

  always_comb begin
    logic [6:0]       len_e;
    logic [3:0]       dlen;
    logic [CBW-1:0]   cwlen;
    logic [REM_W-1:0] rmask;
    logic [REM_W-1:0] pmask;
    logic [REM_W-1:0] rem_sh;
    logic [7:0]       sh;
    logic             bitv;
    logic             msb;
    logic             err;
    logic [7:0]       dw;
    logic             ready;
    logic [7:0]       pbyte;
    logic [1:0]       n;
    crcc_out_t        res;

    pad_nxt = pad_r;
    rem_nxt = rem_r;
    ds_nxt  = ds_r;
    cbc_nxt = cbc_r;
    pb_nxt  = pb_r;
    pbc_nxt = pbc_r;
    cw_nxt  = cw_r;
    err_nxt = err_r;
    step    = '0;
    n       = 2'd0;
    sh      = '0;
    bitv    = 1'b0;
    msb     = 1'b0;
    rem_sh  = '0;
    err     = 1'b0;
    dw      = '0;
    ready   = 1'b0;
    pbyte   = '0;
    res     = '0;

    len_e = {1'b0, gen_len};
    if (len_e == 7'd0) len_e = 7'd1;
    if (len_e > 7'(MAX_GEN_BITS)) len_e = 7'(MAX_GEN_BITS);
    dlen  = dw_eight ? DW_WIDE : DW_NARROW;
    cwlen = CBW'(7'(dlen) + len_e - 7'd1);
    rmask = ~({REM_W{1'b1}} << (len_e - 7'd1));
    pmask = REM_W'(gen_poly) & rmask;

    if (item.is_header) begin
      pad_nxt = item.in_byte;
      rem_nxt = '0;
      ds_nxt  = '0;
      cbc_nxt = '0;
      pb_nxt  = '0;
      pbc_nxt = '0;
    end else begin
      sh = item.in_byte;
      for (int i = 0; i < 8; i++) begin
        bitv = sh[7];
        sh   = sh << 1;
        if (pad_nxt != 8'd0) begin
          pad_nxt = pad_nxt - 8'd1;
        end else begin
          if (cbc_nxt < CBW'(dlen)) ds_nxt = {ds_nxt[6:0], bitv};
          if (len_e > 7'd1) begin
            rem_sh  = rem_nxt >> (len_e - 7'd2);
            msb     = rem_sh[0];
            rem_nxt = ((rem_nxt << 1) | REM_W'(bitv)) & rmask;
            if (msb) rem_nxt = rem_nxt ^ pmask;
          end
          cbc_nxt = cbc_nxt + CBW'(1);
          if (cbc_nxt >= cwlen && n < 2'd2) begin
            err = (rem_nxt != '0);
            dw  = ds_nxt & (dw_eight ? 8'hFF : 8'h0F);
            if (cw_nxt != 32'hFFFF_FFFF) cw_nxt = cw_nxt + 32'd1;
            if (err && err_nxt != 32'hFFFF_FFFF) err_nxt = err_nxt + 32'd1;
            pb_nxt  = (pb_nxt << dlen) | dw;
            pbc_nxt = pbc_nxt + dlen;
            ready   = 1'b0;
            pbyte   = 8'd0;
            if (pbc_nxt >= PACK_FULL) begin
              ready   = 1'b1;
              pbyte   = pb_nxt;
              pb_nxt  = '0;
              pbc_nxt = '0;
            end
            res.dataword       = dw;
            res.crc_error      = err;
            res.byte_ready     = ready;
            res.data_byte      = pbyte;
            res.codeword_total = cw_nxt;
            res.error_total    = err_nxt;
            res.last_of_run    = 1'b0;
            if (n == 2'd0) step.first = res;
            else step.second = res;
            n       = n + 2'd1;
            rem_nxt = '0;
            ds_nxt  = '0;
            cbc_nxt = '0;
          end
        end
      end
    end

    step.num = n;
    if (n == 2'd1) step.first.last_of_run = 1'b1;
    if (n == 2'd2) step.second.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r <= '0;
      rem_r <= '0;
      ds_r  <= '0;
      cbc_r <= '0;
      pb_r  <= '0;
      pbc_r <= '0;
      cw_r  <= '0;
      err_r <= '0;
    end else if (step_en) begin
      pad_r <= pad_nxt;
      rem_r <= rem_nxt;
      ds_r  <= ds_nxt;
      cbc_r <= cbc_nxt;
      pb_r  <= pb_nxt;
      pbc_r <= pbc_nxt;
      cw_r  <= cw_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

// File: rtl/crcc_res_buf.sv
// Two-slot result buffer that drains one result item per output handshake.
// Depends on crcc_pkg.
module crcc_res_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  crcc_pkg::crcc_step_t step,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crcc_pkg::crcc_out_t  out_item
);
  import crcc_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  crcc_out_t  slot0_r, slot1_r;
  logic       take;
  logic [1:0] cnt_pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = slot0_r;
  assign take      = out_valid && !out_stall;
  assign cnt_pop   = cnt_r - {1'b0, take};
  assign free      = (cnt_pop == 2'd0);

  always_comb begin
    cnt_nxt = cnt_pop;
    if (load) cnt_nxt = step.num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0_r <= step.first;
      slot1_r <= step.second;
    end else if (take) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

// File: rtl/crc_codeword_checker_top.sv
// Timing: an item is registered at its accepting edge, its results are loaded
// into the result buffer when step_en allows, and results leave from slot 0.
// Throughput: one byte item per cycle while each byte finishes at most one
// codeword and out_stall is low; a byte that finishes two holds back a later
// byte with results until the single-result output port drains the buffer.
// Reset: synchronous active-low rst_n clears state and counters, loads defaults.
module crc_codeword_checker_top #(
  parameter int MAX_GEN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crcc_pkg::crcc_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output crcc_pkg::crcc_out_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import crcc_pkg::*;

  logic [31:0] gen_poly_r;
  logic [5:0]  gen_len_r;
  logic        dw_eight_r;
  logic        in_vld_r;
  crcc_in_t    in_item_r;
  crcc_step_t  step;
  logic        buf_free;
  logic        step_en;
  logic        buf_load;

  assign step_en  = in_vld_r && ((step.num == 2'd0) || buf_free);
  assign buf_load = step_en && (step.num != 2'd0);
  assign in_stall = in_vld_r && !step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_poly_r <= GEN_POLY_RST;
      gen_len_r  <= GEN_LEN_RST;
      dw_eight_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GEN_POLY: gen_poly_r <= cfg_wdata;
        CFG_GEN_LEN:  gen_len_r  <= cfg_wdata[5:0];
        CFG_DW_EIGHT: dw_eight_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (step_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_item;
  end

  crcc_core #(
    .MAX_GEN_BITS(MAX_GEN_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .item     (in_item_r),
    .gen_poly (gen_poly_r),
    .gen_len  (gen_len_r),
    .dw_eight (dw_eight_r),
    .step     (step)
  );

  crcc_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (buf_load),
    .step      (step),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    buf_load |-> buf_free)
    else $error("result buffer loaded while not free");

  a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step.num == 2'd2) |-> (!step.first.last_of_run && step.second.last_of_run))
    else $error("last_of_run misplaced on a two-result item");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !step_en) |=> (in_vld_r && $stable(in_item_r)))
    else $error("held item lost or changed");

  a_header_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && in_item_r.is_header) |-> (step.num == 2'd0))
    else $error("header item produced a result");
`endif

endmodule
